// File: design/ptcp_pkg.sv
// ============================================================================
// ptcp_pkg
// Shared constants and types for the point-triangle closest-point pipeline.
// ============================================================================
package ptcp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS      = 16;
    localparam int Q_BITS         = FRAC_BITS + 1;

    localparam int DOT_STAGES   = 3;
    localparam int DET_STAGES   = 3;
    localparam int SEL_STAGES   = 2;
    localparam int DIV_STAGES   = Q_BITS + 1;
    localparam int BLEND_STAGES = 5;
    localparam int LATENCY      = DOT_STAGES + DET_STAGES + SEL_STAGES + DIV_STAGES
                                  + BLEND_STAGES;

    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_AB = 3'd2,
        REG_C  = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } t_region;

endpackage

// File: design/point_triangle_closest_point_top.sv
// ============================================================================
// point_triangle_closest_point_top
// Closest point on a triangle to a query point, Voronoi region and squared
// distance, Q8.8 coordinates, fully pipelined.
// ============================================================================
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  request   | start, busy            | i_query_*, i_vert_a_*, _b_*, _c_*
//  result    | o_valid (1-cycle)      | o_closest_*, o_dist_squared, o_region
//
//  One request per cycle while busy is low; the pipeline is the 18-stage
//  quotient divider plus 13 arithmetic stages.
//  busy is high during reset and until the ready flag is registered after it, low otherwise.
//  Synchronous active-low reset clears all valid bits; data regs are not reset.
//  No stalls: results are presented for one cycle and the pipeline never waits.
// ============================================================================
module point_triangle_closest_point_top #(
    parameter int COORD_BITS = ptcp_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COORD_BITS-1:0]   i_query_x,
    input  logic [COORD_BITS-1:0]   i_query_y,
    input  logic [COORD_BITS-1:0]   i_query_z,
    input  logic [COORD_BITS-1:0]   i_vert_a_x,
    input  logic [COORD_BITS-1:0]   i_vert_a_y,
    input  logic [COORD_BITS-1:0]   i_vert_a_z,
    input  logic [COORD_BITS-1:0]   i_vert_b_x,
    input  logic [COORD_BITS-1:0]   i_vert_b_y,
    input  logic [COORD_BITS-1:0]   i_vert_b_z,
    input  logic [COORD_BITS-1:0]   i_vert_c_x,
    input  logic [COORD_BITS-1:0]   i_vert_c_y,
    input  logic [COORD_BITS-1:0]   i_vert_c_z,
    output logic                    o_valid,
    output logic [COORD_BITS-1:0]   o_closest_x,
    output logic [COORD_BITS-1:0]   o_closest_y,
    output logic [COORD_BITS-1:0]   o_closest_z,
    output logic [2*COORD_BITS+1:0] o_dist_squared,
    output logic [2:0]              o_region
);

    localparam int C   = COORD_BITS;
    localparam int D   = 2 * C + 4;
    localparam int V   = 2 * D + 1;
    localparam int W   = 2 * D + 3;
    localparam int QB  = ptcp_pkg::Q_BITS;
    localparam int PTW = 12 * C;
    localparam int DTW = 3 + 3 * C + 6 * (C + 1) + 3 * C;

    logic r_rdy;
    logic w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy  = ~r_rdy;
    assign w_acc = start & r_rdy;

    // dot products
    logic                   dot_vld;
    logic [2:0][C-1:0]      dot_p, dot_a, dot_b, dot_c;
    logic [5:0][D-1:0]      dot_d;

    ptcp_dot #(.C(C)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_p     ({i_query_z, i_query_y, i_query_x}),
        .i_a     ({i_vert_a_z, i_vert_a_y, i_vert_a_x}),
        .i_b     ({i_vert_b_z, i_vert_b_y, i_vert_b_x}),
        .i_c     ({i_vert_c_z, i_vert_c_y, i_vert_c_x}),
        .o_vld   (dot_vld),
        .o_p     (dot_p),
        .o_a     (dot_a),
        .o_b     (dot_b),
        .o_c     (dot_c),
        .o_d     (dot_d)
    );

    // determinants
    logic                   det_vld;
    logic [5:0][D-1:0]      det_d;
    logic [3:0][D:0]        det_ed;
    logic [V-1:0]           det_va, det_vb, det_vc;
    logic [PTW-1:0]         det_tag;

    ptcp_det #(.D(D), .TW(PTW)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dot_vld),
        .i_d     (dot_d),
        .i_tag   ({dot_p, dot_a, dot_b, dot_c}),
        .o_vld   (det_vld),
        .o_d     (det_d),
        .o_ed    (det_ed),
        .o_va    (det_va),
        .o_vb    (det_vb),
        .o_vc    (det_vc),
        .o_tag   (det_tag)
    );

    // region decision
    logic signed [D-1:0]    w_d1, w_d2, w_d3, w_d4, w_d5, w_d6;
    logic signed [D:0]      w_n43, w_n56;
    logic signed [V-1:0]    w_va, w_vb, w_vc;
    ptcp_pkg::t_region      n7_region;

    assign w_d1  = $signed(det_d[0]);
    assign w_d2  = $signed(det_d[1]);
    assign w_d3  = $signed(det_d[2]);
    assign w_d4  = $signed(det_d[3]);
    assign w_d5  = $signed(det_d[4]);
    assign w_d6  = $signed(det_d[5]);
    assign w_n43 = $signed(det_ed[2]);
    assign w_n56 = $signed(det_ed[3]);
    assign w_va  = $signed(det_va);
    assign w_vb  = $signed(det_vb);
    assign w_vc  = $signed(det_vc);

    always_comb begin
        priority if (w_d1 <= 0 && w_d2 <= 0) begin
            n7_region = ptcp_pkg::REG_A;
        end else if (w_d3 >= 0 && w_d4 <= w_d3) begin
            n7_region = ptcp_pkg::REG_B;
        end else if (w_vc <= 0 && w_d1 >= 0 && w_d3 <= 0) begin
            n7_region = ptcp_pkg::REG_AB;
        end else if (w_d6 >= 0 && w_d5 <= w_d6) begin
            n7_region = ptcp_pkg::REG_C;
        end else if (w_vb <= 0 && w_d2 >= 0 && w_d6 <= 0) begin
            n7_region = ptcp_pkg::REG_AC;
        end else if (w_va <= 0 && w_n43 >= 0 && w_n56 >= 0) begin
            n7_region = ptcp_pkg::REG_BC;
        end else begin
            n7_region = ptcp_pkg::REG_IN;
        end
    end

    logic                   r7_v;
    ptcp_pkg::t_region      r7_region;
    logic signed [D-1:0]    r7_d1, r7_d2;
    logic signed [D:0]      r7_dab, r7_dac, r7_n43;
    logic signed [D+1:0]    r7_den_bc;
    logic signed [V-1:0]    r7_vb, r7_vc;
    logic signed [W-1:0]    r7_den_in;
    logic [PTW-1:0]         r7_pt;

    always_ff @(posedge i_clk) begin
        r7_region <= n7_region;
        r7_d1     <= w_d1;
        r7_d2     <= w_d2;
        r7_dab    <= $signed(det_ed[0]);
        r7_dac    <= $signed(det_ed[1]);
        r7_n43    <= w_n43;
        r7_den_bc <= (D+2)'(w_n43) + (D+2)'(w_n56);
        r7_vb     <= w_vb;
        r7_vc     <= w_vc;
        r7_den_in <= W'(w_va) + W'(w_vb) + W'(w_vc);
        r7_pt     <= det_tag;
    end

    // divider operand select
    logic [2:0][C-1:0]      w7_p, w7_a, w7_b, w7_c;
    logic [2:0][C-1:0]      n8_base, n8_end;
    logic signed [W-1:0]    n8_num1, n8_num2, n8_den;

    assign {w7_p, w7_a, w7_b, w7_c} = r7_pt;

    always_comb begin
        n8_num1 = '0;
        n8_num2 = '0;
        n8_den  = '0;
        n8_base = w7_a;
        n8_end  = w7_b;
        unique case (r7_region)
            ptcp_pkg::REG_A: begin
                n8_base = w7_a;
            end
            ptcp_pkg::REG_B: begin
                n8_base = w7_b;
            end
            ptcp_pkg::REG_AB: begin
                n8_num1 = W'(r7_d1);
                n8_den  = W'(r7_dab);
            end
            ptcp_pkg::REG_C: begin
                n8_base = w7_c;
            end
            ptcp_pkg::REG_AC: begin
                n8_num1 = W'(r7_d2);
                n8_den  = W'(r7_dac);
                n8_end  = w7_c;
            end
            ptcp_pkg::REG_BC: begin
                n8_num1 = W'(r7_n43);
                n8_den  = W'(r7_den_bc);
                n8_base = w7_b;
                n8_end  = w7_c;
            end
            ptcp_pkg::REG_IN: begin
                n8_num1 = W'(r7_vb);
                n8_num2 = W'(r7_vc);
                n8_den  = r7_den_in;
            end
            default: begin
                n8_base = w7_a;
            end
        endcase
    end

    logic                   r8_v;
    logic                   r8_zero;
    logic [W-1:0]           r8_num1, r8_num2, r8_den;
    logic [2:0]             r8_region;
    logic [2:0][C-1:0]      r8_base, r8_p;
    logic [2:0][C:0]        r8_e1, r8_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else begin
            r7_v <= det_vld;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_zero   <= n8_den <= 0;
        r8_num1   <= n8_num1[W-1] ? '0 : n8_num1;
        r8_num2   <= n8_num2[W-1] ? '0 : n8_num2;
        r8_den    <= n8_den;
        r8_region <= r7_region;
        r8_base   <= n8_base;
        r8_p      <= w7_p;
        for (int k = 0; k < 3; k++) begin
            r8_e1[k] <= (C+1)'($signed(n8_end[k])) - (C+1)'($signed(n8_base[k]));
            r8_e2[k] <= (C+1)'($signed(w7_c[k])) - (C+1)'($signed(w7_a[k]));
        end
    end

    // quotients
    logic                   div_vld;
    logic [QB-1:0]          div_q1, div_q2;
    logic [DTW-1:0]         div_tag;
    logic [2:0]             div_region;
    logic [2:0][C-1:0]      div_base, div_p;
    logic [2:0][C:0]        div_e1, div_e2;

    ptcp_div #(.W(W), .TW(DTW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r8_v),
        .i_zero  (r8_zero),
        .i_num1  (r8_num1),
        .i_num2  (r8_num2),
        .i_den   (r8_den),
        .i_tag   ({r8_region, r8_base, r8_e1, r8_e2, r8_p}),
        .o_vld   (div_vld),
        .o_q1    (div_q1),
        .o_q2    (div_q2),
        .o_tag   (div_tag)
    );

    assign {div_region, div_base, div_e1, div_e2, div_p} = div_tag;

    // closest point and distance
    logic [2:0][C-1:0]      bl_q;

    ptcp_blend #(.C(C)) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (div_vld),
        .i_q1     (div_q1),
        .i_q2     (div_q2),
        .i_region (div_region),
        .i_base   (div_base),
        .i_e1     (div_e1),
        .i_e2     (div_e2),
        .i_p      (div_p),
        .o_vld    (o_valid),
        .o_q      (bl_q),
        .o_dist   (o_dist_squared),
        .o_region (o_region)
    );

    assign o_closest_x = bl_q[0];
    assign o_closest_y = bl_q[1];
    assign o_closest_z = bl_q[2];

endmodule

// File: design/ptcp_dot.sv
// ============================================================================
// ptcp_dot
// Edge and offset vectors, then the six Voronoi dot products d1..d6.
// ============================================================================
module ptcp_dot #(
    parameter int C = ptcp_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [2:0][C-1:0]        i_p,
    input  logic [2:0][C-1:0]        i_a,
    input  logic [2:0][C-1:0]        i_b,
    input  logic [2:0][C-1:0]        i_c,
    output logic                     o_vld,
    output logic [2:0][C-1:0]        o_p,
    output logic [2:0][C-1:0]        o_a,
    output logic [2:0][C-1:0]        o_b,
    output logic [2:0][C-1:0]        o_c,
    output logic [5:0][2*C+3:0]      o_d
);

    localparam int D = 2 * C + 4;
    localparam int M = 2 * C + 2;

    logic signed [C:0]   r_ab [3];
    logic signed [C:0]   r_ac [3];
    logic signed [C:0]   r_ap [3];
    logic signed [C:0]   r_bp [3];
    logic signed [C:0]   r_cp [3];
    logic signed [M-1:0] r_m  [6][3];
    logic [5:0][D-1:0]   r_d;
    logic [3:0][2:0][C-1:0] r_pt [3];
    logic [2:0]          r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ab[k] <= (C+1)'($signed(i_b[k])) - (C+1)'($signed(i_a[k]));
            r_ac[k] <= (C+1)'($signed(i_c[k])) - (C+1)'($signed(i_a[k]));
            r_ap[k] <= (C+1)'($signed(i_p[k])) - (C+1)'($signed(i_a[k]));
            r_bp[k] <= (C+1)'($signed(i_p[k])) - (C+1)'($signed(i_b[k]));
            r_cp[k] <= (C+1)'($signed(i_p[k])) - (C+1)'($signed(i_c[k]));
            r_m[0][k] <= r_ab[k] * r_ap[k];
            r_m[1][k] <= r_ac[k] * r_ap[k];
            r_m[2][k] <= r_ab[k] * r_bp[k];
            r_m[3][k] <= r_ac[k] * r_bp[k];
            r_m[4][k] <= r_ab[k] * r_cp[k];
            r_m[5][k] <= r_ac[k] * r_cp[k];
        end
        for (int j = 0; j < 6; j++) begin
            r_d[j] <= D'(r_m[j][0]) + D'(r_m[j][1]) + D'(r_m[j][2]);
        end
        r_pt[0] <= {i_p, i_a, i_b, i_c};
        r_pt[1] <= r_pt[0];
        r_pt[2] <= r_pt[1];
    end

    assign o_vld = r_v[2];
    assign o_d   = r_d;
    assign {o_p, o_a, o_b, o_c} = r_pt[2];

endmodule

// File: design/ptcp_det.sv
// ============================================================================
// ptcp_det
// Region determinants va, vb, vc from split partial products, plus the
// dot-product differences used by the edge tests.
// ============================================================================
module ptcp_det #(
    parameter int D  = 2 * ptcp_pkg::COORD_BITS_DEF + 4,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [5:0][D-1:0]    i_d,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_vld,
    output logic [5:0][D-1:0]    o_d,
    output logic [3:0][D:0]      o_ed,
    output logic [2*D:0]         o_va,
    output logic [2*D:0]         o_vb,
    output logic [2*D:0]         o_vc,
    output logic [TW-1:0]        o_tag
);

    localparam int L = D / 2;
    localparam int H = D - L;
    localparam int P = 2 * D;

    logic signed [D-1:0]     w_x [6];
    logic signed [D-1:0]     w_y [6];
    logic signed [2*H-1:0]   r_hh [6];
    logic signed [H+L:0]     r_hl [6];
    logic signed [H+L:0]     r_lh [6];
    logic signed [2*L+1:0]   r_ll [6];
    logic signed [P-1:0]     r_pr [6];
    logic signed [P:0]       r_va, r_vb, r_vc;
    logic [3:0][D:0]         r_ed;
    logic [5:0][D-1:0]       r_d [3];
    logic [TW-1:0]           r_tag [3];
    logic [2:0]              r_v;

    // products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    always_comb begin
        w_x[0] = $signed(i_d[0]); w_y[0] = $signed(i_d[3]);
        w_x[1] = $signed(i_d[2]); w_y[1] = $signed(i_d[1]);
        w_x[2] = $signed(i_d[4]); w_y[2] = $signed(i_d[1]);
        w_x[3] = $signed(i_d[0]); w_y[3] = $signed(i_d[5]);
        w_x[4] = $signed(i_d[2]); w_y[4] = $signed(i_d[5]);
        w_x[5] = $signed(i_d[4]); w_y[5] = $signed(i_d[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r_hh[i] <= $signed(w_x[i][D-1:L]) * $signed(w_y[i][D-1:L]);
            r_hl[i] <= $signed(w_x[i][D-1:L]) * $signed({1'b0, w_y[i][L-1:0]});
            r_lh[i] <= $signed({1'b0, w_x[i][L-1:0]}) * $signed(w_y[i][D-1:L]);
            r_ll[i] <= $signed({1'b0, w_x[i][L-1:0]}) * $signed({1'b0, w_y[i][L-1:0]});
            r_pr[i] <= (P'(r_hh[i]) <<< (2 * L)) + (P'(r_hl[i]) <<< L)
                     + (P'(r_lh[i]) <<< L) + P'(r_ll[i]);
        end
        r_vc <= (P+1)'(r_pr[0]) - (P+1)'(r_pr[1]);
        r_vb <= (P+1)'(r_pr[2]) - (P+1)'(r_pr[3]);
        r_va <= (P+1)'(r_pr[4]) - (P+1)'(r_pr[5]);
        r_ed[0] <= (D+1)'($signed(r_d[1][0])) - (D+1)'($signed(r_d[1][2]));
        r_ed[1] <= (D+1)'($signed(r_d[1][1])) - (D+1)'($signed(r_d[1][5]));
        r_ed[2] <= (D+1)'($signed(r_d[1][3])) - (D+1)'($signed(r_d[1][2]));
        r_ed[3] <= (D+1)'($signed(r_d[1][4])) - (D+1)'($signed(r_d[1][5]));
        r_d[0]   <= i_d;
        r_d[1]   <= r_d[0];
        r_d[2]   <= r_d[1];
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
    end

    assign o_vld = r_v[2];
    assign o_d   = r_d[2];
    assign o_ed  = r_ed;
    assign o_va  = r_va;
    assign o_vb  = r_vb;
    assign o_vc  = r_vc;
    assign o_tag = r_tag[2];

endmodule

// File: design/ptcp_div.sv
// ============================================================================
// ptcp_div
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over a shared denominator. Quotient is num * 2^F / den, capped at 1.0, or zero when i_zero is set.
// ============================================================================
module ptcp_div #(
    parameter int W  = 4 * ptcp_pkg::COORD_BITS_DEF + 11,
    parameter int TW = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic                         i_zero,
    input  logic [W-1:0]                 i_num1,
    input  logic [W-1:0]                 i_num2,
    input  logic [W-1:0]                 i_den,
    input  logic [TW-1:0]                i_tag,
    output logic                         o_vld,
    output logic [ptcp_pkg::Q_BITS-1:0]  o_q1,
    output logic [ptcp_pkg::Q_BITS-1:0]  o_q2,
    output logic [TW-1:0]                o_tag
);

    localparam int QB = ptcp_pkg::Q_BITS;
    localparam int NS = QB;
    localparam logic [QB-1:0] ONE = QB'(1) << ptcp_pkg::FRAC_BITS;

    logic [W-1:0]  r_rem1 [NS];
    logic [W-1:0]  r_rem2 [NS];
    logic [W-1:0]  r_den  [NS];
    logic [QB-1:0] r_q1   [NS];
    logic [QB-1:0] r_q2   [NS];
    logic          r_ov1  [NS];
    logic          r_ov2  [NS];
    logic          r_zero [NS];
    logic [TW-1:0] r_tag  [NS];
    logic [NS-1:0] r_v;
    logic [QB-1:0] r_out_q1, r_out_q2;
    logic [TW-1:0] r_out_tag;
    logic          r_out_v;

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [W:0]    w_t1, w_t2;
        logic [W-1:0]  w_den;
        logic [QB-1:0] w_q1, w_q2;
        logic          w_ov1, w_ov2, w_zero, w_b1, w_b2;
        logic [TW-1:0] w_tag;

        if (s == 0) begin : g_first
            assign w_t1   = {1'b0, i_num1};
            assign w_t2   = {1'b0, i_num2};
            assign w_den  = i_den;
            assign w_q1   = '0;
            assign w_q2   = '0;
            assign w_ov1  = {1'b0, i_num1} >= {i_den, 1'b0};
            assign w_ov2  = {1'b0, i_num2} >= {i_den, 1'b0};
            assign w_zero = i_zero;
            assign w_tag  = i_tag;
        end else begin : g_next
            assign w_t1   = {r_rem1[s-1], 1'b0};
            assign w_t2   = {r_rem2[s-1], 1'b0};
            assign w_den  = r_den[s-1];
            assign w_q1   = r_q1[s-1];
            assign w_q2   = r_q2[s-1];
            assign w_ov1  = r_ov1[s-1];
            assign w_ov2  = r_ov2[s-1];
            assign w_zero = r_zero[s-1];
            assign w_tag  = r_tag[s-1];
        end

        assign w_b1 = w_t1 >= {1'b0, w_den};
        assign w_b2 = w_t2 >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            r_rem1[s] <= w_b1 ? W'(w_t1 - {1'b0, w_den}) : w_t1[W-1:0];
            r_rem2[s] <= w_b2 ? W'(w_t2 - {1'b0, w_den}) : w_t2[W-1:0];
            r_q1[s]   <= {w_q1[QB-2:0], w_b1};
            r_q2[s]   <= {w_q2[QB-2:0], w_b2};
            r_den[s]  <= w_den;
            r_ov1[s]  <= w_ov1;
            r_ov2[s]  <= w_ov2;
            r_zero[s] <= w_zero;
            r_tag[s]  <= w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_v     <= {r_v[NS-2:0], i_vld};
            r_out_v <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_zero[NS-1]) begin
            r_out_q1 <= '0;
            r_out_q2 <= '0;
        end else begin
            r_out_q1 <= (r_ov1[NS-1] || r_q1[NS-1] > ONE) ? ONE : r_q1[NS-1];
            r_out_q2 <= (r_ov2[NS-1] || r_q2[NS-1] > ONE) ? ONE : r_q2[NS-1];
        end
        r_out_tag <= r_tag[NS-1];
    end

    assign o_vld = r_out_v;
    assign o_q1  = r_out_q1;
    assign o_q2  = r_out_q2;
    assign o_tag = r_out_tag;

endmodule

// File: design/ptcp_blend.sv
// ============================================================================
// ptcp_blend
// Closest point from base + round(e1*q1 + e2*q2), saturation, then the
// squared distance to the query point.
// ============================================================================
module ptcp_blend #(
    parameter int C = ptcp_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [ptcp_pkg::Q_BITS-1:0]  i_q1,
    input  logic [ptcp_pkg::Q_BITS-1:0]  i_q2,
    input  logic [2:0]                   i_region,
    input  logic [2:0][C-1:0]            i_base,
    input  logic [2:0][C:0]              i_e1,
    input  logic [2:0][C:0]              i_e2,
    input  logic [2:0][C-1:0]            i_p,
    output logic                         o_vld,
    output logic [2:0][C-1:0]            o_q,
    output logic [2*C+1:0]               o_dist,
    output logic [2:0]                   o_region
);

    localparam int QB = ptcp_pkg::Q_BITS;
    localparam int F  = ptcp_pkg::FRAC_BITS;
    localparam int MW = C + QB + 2;
    localparam int SW = MW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (C - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic signed [MW-1:0]  r_m1 [3];
    logic signed [MW-1:0]  r_m2 [3];
    logic [2:0][C-1:0]     r_b1, r_p1, r_p2;
    logic [2:0]            r_rg1, r_rg2, r_rg3, r_rg4, r_rg5;
    logic signed [SW-1:0]  w_sum [3];
    logic signed [SW-1:0]  w_val [3];
    logic [2:0][C-1:0]     r_q2, r_q3, r_q4, r_q5;
    logic signed [C:0]     r_e3 [3];
    logic signed [2*C+1:0] r_sq4 [3];
    logic [2*C+1:0]        r_dist5;
    logic [4:0]            r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_vld};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = (SW'(r_m1[k]) + SW'(r_m2[k]) + HALF) >>> F;
            w_val[k] = w_sum[k] + SW'($signed(r_b1[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_m1[k] <= $signed(i_e1[k]) * $signed({1'b0, i_q1});
            r_m2[k] <= $signed(i_e2[k]) * $signed({1'b0, i_q2});
            if (w_val[k] > MAXV) begin
                r_q2[k] <= C'(MAXV);
            end else if (w_val[k] < MINV) begin
                r_q2[k] <= C'(MINV);
            end else begin
                r_q2[k] <= C'(w_val[k]);
            end
            r_e3[k]  <= (C+1)'($signed(r_p2[k])) - (C+1)'($signed(r_q2[k]));
            r_sq4[k] <= r_e3[k] * r_e3[k];
        end
        r_dist5 <= $unsigned(r_sq4[0]) + $unsigned(r_sq4[1]) + $unsigned(r_sq4[2]);
        r_b1  <= i_base;
        r_p1  <= i_p;
        r_p2  <= r_p1;
        r_q3  <= r_q2;
        r_q4  <= r_q3;
        r_q5  <= r_q4;
        r_rg1 <= i_region;
        r_rg2 <= r_rg1;
        r_rg3 <= r_rg2;
        r_rg4 <= r_rg3;
        r_rg5 <= r_rg4;
    end

    assign o_vld    = r_v[4];
    assign o_q      = r_q5;
    assign o_dist   = r_dist5;
    assign o_region = r_rg5;

endmodule

// File: design/ptcp_chk.sv
// ============================================================================
// ptcp_chk
// Port-level checks for the closest-point pipeline, bound to the top level.
// ============================================================================
module ptcp_chk #(
    parameter int COORD_BITS = ptcp_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [COORD_BITS-1:0] i_vert_a_x,
    input logic [COORD_BITS-1:0] i_vert_a_y,
    input logic [COORD_BITS-1:0] i_vert_a_z,
    input logic [COORD_BITS-1:0] i_vert_b_x,
    input logic [COORD_BITS-1:0] i_vert_b_y,
    input logic [COORD_BITS-1:0] i_vert_b_z,
    input logic [COORD_BITS-1:0] i_vert_c_x,
    input logic [COORD_BITS-1:0] i_vert_c_y,
    input logic [COORD_BITS-1:0] i_vert_c_z,
    input logic                  o_valid,
    input logic [COORD_BITS-1:0] o_closest_x,
    input logic [COORD_BITS-1:0] o_closest_y,
    input logic [COORD_BITS-1:0] o_closest_z,
    input logic [2:0]            o_region
);

    localparam int LAT = ptcp_pkg::LATENCY;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] r_cnt;
    logic          r_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_cnt != CW'(LAT)) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign r_up = (r_cnt == CW'(LAT));

    ap_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_up |-> (o_valid == $past(start && !busy, LAT)))
        else $error("result strobe does not match request latency");

    ap_vert_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == ptcp_pkg::REG_A) |->
        (o_closest_x == $past(i_vert_a_x, LAT) && o_closest_y == $past(i_vert_a_y, LAT)
         && o_closest_z == $past(i_vert_a_z, LAT)))
        else $error("vertex a region does not return vertex a");

    ap_vert_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == ptcp_pkg::REG_B) |->
        (o_closest_x == $past(i_vert_b_x, LAT) && o_closest_y == $past(i_vert_b_y, LAT)
         && o_closest_z == $past(i_vert_b_z, LAT)))
        else $error("vertex b region does not return vertex b");

    ap_vert_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == ptcp_pkg::REG_C) |->
        (o_closest_x == $past(i_vert_c_x, LAT) && o_closest_y == $past(i_vert_c_y, LAT)
         && o_closest_z == $past(i_vert_c_z, LAT)))
        else $error("vertex c region does not return vertex c");

endmodule

bind point_triangle_closest_point_top ptcp_chk #(.COORD_BITS(COORD_BITS)) u_ptcp_chk (.*);
